>>> hdl/ese_pkg.sv
// Shared types and constants of the encoder speed estimator.
package ese_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned CountW      = 32;
  localparam int unsigned CprW        = 16;
  localparam int unsigned DenW        = CountW + CprW;
  localparam int unsigned ScaleW      = 24;
  localparam int unsigned ProdW       = CountW + ScaleW;

  // 60000 ms per minute times 256 for the Q24.8 result.
  localparam logic [ScaleW-1:0] RpmScale = 24'd15360000;
  localparam logic [CprW-1:0]   CprReset = 16'd3960;

  // Register indexes on the configuration port.
  localparam logic RegCountsPerRev = 1'b0;

  typedef struct packed {
    logic [31:0]        sample_time_ms;
    logic signed [31:0] count_ch0;
    logic signed [31:0] count_ch1;
    logic signed [31:0] count_ch2;
    logic signed [31:0] count_ch3;
  } ese_in_t;

  typedef struct packed {
    logic signed [31:0] delta_ch0;
    logic signed [31:0] delta_ch1;
    logic signed [31:0] delta_ch2;
    logic signed [31:0] delta_ch3;
    logic signed [31:0] rpm_ch0;
    logic signed [31:0] rpm_ch1;
    logic signed [31:0] rpm_ch2;
    logic signed [31:0] rpm_ch3;
    logic               speed_valid;
  } ese_out_t;

  typedef struct packed {
    logic start;
    logic take;
  } ese_lane_ctrl_t;

  typedef struct packed {
    logic done;
  } ese_lane_status_t;

endpackage

>>> hdl/encoder_speed_estimator_core.sv
// Encoder speed estimator top level: register port, sample state, lanes and merge.
//
// Each accepted item is one sample: a millisecond tick and four cumulative encoder counts.
// The result gives the wrapping count delta of every channel and its speed in rpm as signed
// Q24.8, delta*60000*256/(counts_per_rev*elapsed), where elapsed is the wrapping tick
// difference in milliseconds, truncated toward zero and saturated; speeds are zero and
// speed_valid low on the first sample or when no time has elapsed.
// One item is in work at a time; a new one is taken only once the last result has been handed
// on, which waits for the output to be free. The steps are capture, the magnitude and the
// denominator product, one scaling multiply, one range check, 32 steps of the one-bit-per-cycle
// divider in each channel lane, and the hand-over of the result to the output register.
// The next item may be accepted while the previous result waits in the output register.
// counts_per_rev is at byte address 0 of the register port; zero counts as one.
module encoder_speed_estimator_core import ese_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ese_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output ese_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CprW-1:0]   cpr_q;
  logic [CprW-1:0]   cpr_eff;
  logic              busy_q;
  logic              start_q;
  logic              have_sample_q;
  logic              speed_valid_q;
  logic [31:0]       last_time_q;
  logic [31:0]       elapsed_q;
  logic [31:0]       elapsed_d;
  logic [DenW-1:0]   den_q;
  logic [CountW-1:0] last_cnt_q [NumChannels];
  logic [CountW-1:0] delta_q    [NumChannels];
  logic [CountW-1:0] cnt_in     [NumChannels];
  logic [CountW-1:0] rpm        [NumChannels];
  ese_lane_status_t  status     [NumChannels];
  ese_lane_ctrl_t    lane_ctrl;
  logic              in_accept;
  logic              take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegCountsPerRev) ? {16'd0, cpr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q <= CprReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegCountsPerRev)) begin
      cpr_q <= pwdata[CprW-1:0];
    end
  end

  assign cpr_eff = (cpr_q == '0) ? CprW'(1) : cpr_q;

  assign cnt_in[0] = in_data_i.count_ch0;
  assign cnt_in[1] = in_data_i.count_ch1;
  assign cnt_in[2] = in_data_i.count_ch2;
  assign cnt_in[3] = in_data_i.count_ch3;

  assign in_stall_o = busy_q;
  assign in_accept  = in_valid_i && !busy_q;
  assign elapsed_d  = in_data_i.sample_time_ms - last_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      start_q       <= 1'b0;
      have_sample_q <= 1'b0;
      last_time_q   <= '0;
      for (int i = 0; i < NumChannels; i++) begin
        last_cnt_q[i] <= '0;
      end
    end else begin
      start_q <= in_accept;
      if (in_accept) begin
        busy_q        <= 1'b1;
        have_sample_q <= 1'b1;
        last_time_q   <= in_data_i.sample_time_ms;
        for (int i = 0; i < NumChannels; i++) begin
          last_cnt_q[i] <= cnt_in[i];
        end
      end else if (take) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      elapsed_q     <= elapsed_d;
      speed_valid_q <= have_sample_q && (elapsed_d != '0);
      for (int i = 0; i < NumChannels; i++) begin
        delta_q[i] <= cnt_in[i] - last_cnt_q[i];
      end
    end
    if (start_q) begin
      den_q <= DenW'(cpr_eff) * DenW'(elapsed_q);
    end
  end

  assign lane_ctrl.start = start_q;
  assign lane_ctrl.take  = take;

  for (genvar g = 0; g < NumChannels; g++) begin : g_lane
    ese_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .delta_i  (delta_q[g]),
      .den_i    (den_q),
      .rpm_o    (rpm[g]),
      .status_o (status[g])
    );
  end

  ese_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .status_i      (status),
    .rpm_i         (rpm),
    .delta_i       (delta_q),
    .speed_valid_i (speed_valid_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_data_o    (out_data_o),
    .take_o        (take)
  );

  // The lanes run in lockstep, so they finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status[0].done == status[1].done) && (status[0].done == status[2].done) &&
    (status[0].done == status[3].done))
    else $error("lanes out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni) take |-> busy_q)
    else $error("result taken with no item in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> busy_q && start_q)
    else $error("accepted item did not start the lanes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.speed_valid) |->
    (out_data_o.rpm_ch0 == 0 && out_data_o.rpm_ch1 == 0 &&
     out_data_o.rpm_ch2 == 0 && out_data_o.rpm_ch3 == 0))
    else $error("speed given without valid flag");

endmodule

>>> hdl/ese_lane.sv
// One channel lane: magnitude, scaling multiply, bit-serial divide and saturation.
module ese_lane import ese_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ese_lane_ctrl_t         ctrl_i,
  input  logic [CountW-1:0]      delta_i,
  input  logic [DenW-1:0]        den_i,
  output logic [CountW-1:0]      rpm_o,
  output ese_lane_status_t       status_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StChk  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;
  logic [CountW-1:0] mag_q, mag_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [CountW-1:0] num_q, num_d;
  logic [DenW:0]     trial;
  logic              qbit;

  assign trial = {rem_q, num_q[CountW-1]};
  assign qbit  = (trial >= {1'b0, den_i});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    mag_d   = mag_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    num_d   = num_q;
    unique case (state_q)
      StIdle: begin
        if (ctrl_i.start) begin
          neg_d   = delta_i[CountW-1];
          mag_d   = delta_i[CountW-1] ? (CountW'(0) - delta_i) : delta_i;
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = ProdW'(mag_q) * ProdW'(RpmScale);
        state_d = StChk;
      end
      StChk: begin
        // A quotient of 2^32 or more saturates whatever its low bits are.
        ovf_d   = (DenW'(prod_q[ProdW-1:CountW]) >= den_i);
        rem_d   = DenW'(prod_q[ProdW-1:CountW]);
        num_d   = prod_q[CountW-1:0];
        cnt_d   = 5'd31;
        state_d = StDiv;
      end
      StDiv: begin
        rem_d = qbit ? DenW'(trial - {1'b0, den_i}) : trial[DenW-1:0];
        num_d = {num_q[CountW-2:0], qbit};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (ctrl_i.take) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    ovf_q  <= ovf_d;
    mag_q  <= mag_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
  end

  always_comb begin
    if (neg_q) begin
      if (ovf_q || (num_q > 32'h8000_0000)) begin
        rpm_o = 32'h8000_0000;
      end else begin
        rpm_o = CountW'(0) - num_q;
      end
    end else begin
      if (ovf_q || num_q[CountW-1]) begin
        rpm_o = 32'h7FFF_FFFF;
      end else begin
        rpm_o = num_q;
      end
    end
  end

  assign status_o.done = (state_q == StFin);

endmodule

>>> hdl/ese_merge.sv
// Merging stage: gathers the lane results into the output register.
module ese_merge import ese_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ese_lane_status_t       status_i [NumChannels],
  input  logic [CountW-1:0]      rpm_i    [NumChannels],
  input  logic [CountW-1:0]      delta_i  [NumChannels],
  input  logic                   speed_valid_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output ese_out_t               out_data_o,
  output logic                   take_o
);

  logic        all_done;
  logic [31:0] rpm_m [NumChannels];
  logic        out_valid_q;
  ese_out_t    out_data_q, out_data_d;

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NumChannels; i++) begin
      all_done = all_done & status_i[i].done;
      rpm_m[i] = speed_valid_i ? rpm_i[i] : '0;
    end
  end

  // The item moves on once every lane has finished and the slot is free.
  assign take_o = all_done && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_data_d.delta_ch0   = delta_i[0];
    out_data_d.delta_ch1   = delta_i[1];
    out_data_d.delta_ch2   = delta_i[2];
    out_data_d.delta_ch3   = delta_i[3];
    out_data_d.rpm_ch0     = rpm_m[0];
    out_data_d.rpm_ch1     = rpm_m[1];
    out_data_d.rpm_ch2     = rpm_m[2];
    out_data_d.rpm_ch3     = rpm_m[3];
    out_data_d.speed_valid = speed_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
